// ===== hdl/frt_pkg.sv =====
`timescale 1ns / 1ps
package frt_pkg;

    localparam int CONTEXTS  = 16;
    localparam int MAX_FRAGS = 64;
    localparam int CTX_W     = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int CNT_W     = $clog2(CONTEXTS + 1);
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [19:0] NS_PER_MS     = 20'd1000000;
    localparam logic [23:0] BYTES_MAX     = 24'hFFFFFF;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_COMPLETE  = 3'd4;
    localparam logic [2:0] ST_NO_FREE   = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;

    typedef struct packed {
        logic        mode;
        logic        header_ok;
        logic [7:0]  port_id;
        logic [31:0] blk_key;
        logic [15:0] strm_tag;
        logic [23:0] blk_bytes;
        logic [6:0]  nfrags;
        logic [7:0]  frag_num;
        logic [15:0] frag_bytes;
        logic [1:0]  frag_flags;
        logic [63:0] time_ns;
    } frt_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic        flags_bad;
        logic [7:0]  port_out;
        logic [15:0] stream_out;
        logic [31:0] block_out;
        logic [23:0] bytes_out;
        logic [6:0]  missing_frags;
        logic        last;
    } frt_result_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture request
        logic search;     // register key match and free slot
        logic push_exec;  // apply push and emit its result
        logic sweep_init; // reset sweep index, register timeout product
        logic sweep_step; // examine one context
        logic sweep_done; // emit closing result
    } frt_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_sweep;
        logic sweep_last; // the context being examined is the final one
    } frt_status_t;

endpackage

// ===== hdl/frt_ctrl.sv =====
`timescale 1ns / 1ps
module frt_ctrl
    import frt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output frt_cmd_t    cmd,
    input  frt_status_t stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_PUSH  = 6'b000100,
        S_SINIT = 6'b001000,
        S_SWEEP = 6'b010000,
        S_SDONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.is_sweep)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SINIT;
                end
                else
                begin
                    cmd.search = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push_exec = 1'b1;
                state_next    = S_IDLE;
            end
            S_SINIT:
            begin
                // Pass on to the sweep; the timeout product was registered on sweep_init.
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_SDONE;
                end
            end
            S_SDONE:
            begin
                cmd.sweep_done = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/frt_datapath.sv =====
`timescale 1ns / 1ps
module frt_datapath
    import frt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frt_req_t    request,
    input  logic [31:0] timeout_val,
    input  frt_cmd_t    cmd,
    output frt_status_t stat,
    output frt_result_t result,
    output logic        result_valid
);

    logic [CONTEXTS-1:0]  valid_reg;
    logic [7:0]           port_mem    [CONTEXTS];
    logic [31:0]          block_mem   [CONTEXTS];
    logic [15:0]          stream_mem  [CONTEXTS];
    logic [23:0]          total_mem   [CONTEXTS];
    logic [6:0]           ftotal_mem  [CONTEXTS];
    logic [63:0]          map_mem     [CONTEXTS];
    logic [6:0]           seen_mem    [CONTEXTS];
    logic [23:0]          bseen_mem   [CONTEXTS];
    logic [63:0]          time_mem    [CONTEXTS];

    frt_req_t             req_reg;
    logic [51:0]          tns_reg;
    logic                 hit_reg;
    logic                 free_ok_reg;
    logic [CTX_W-1:0]     hit_idx_reg;
    logic [CTX_W-1:0]     free_idx_reg;
    logic [CNT_W-1:0]     sidx_reg;
    frt_result_t          result_reg;
    frt_result_t          result_next;
    logic                 result_valid_reg;

    // Associative search over valid contexts, and a free-slot pick among invalid ones.
    logic                 hit_c, free_c;
    logic [CTX_W-1:0]     hit_i, free_i;
    always_comb
    begin
        hit_c  = 1'b0;
        free_c = 1'b0;
        hit_i  = '0;
        free_i = '0;
        for (int i = CONTEXTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i])
            begin
                if (port_mem[i] == req_reg.port_id && block_mem[i] == req_reg.blk_key)
                begin
                    hit_c = 1'b1;
                    hit_i = CTX_W'(i);
                end
            end
            else
            begin
                free_c = 1'b1;
                free_i = CTX_W'(i);
            end
        end
    end

    // Push evaluation against the selected context.
    logic [CTX_W-1:0] c;
    logic             opening;
    logic [6:0]       ftot;
    logic [23:0]      btot;
    logic [15:0]      stot;
    logic [63:0]      pmap;
    logic [6:0]       pseen;
    logic [23:0]      pbytes;
    logic             mismatch, conflict, out_range, dup, complete;
    logic             push_ok, frag_new;
    logic [24:0]      bsum;
    logic [23:0]      bsat;
    logic [6:0]       seen_inc;
    logic [63:0]      bitm;
    always_comb
    begin
        opening  = !hit_reg;
        c        = hit_reg ? hit_idx_reg : free_idx_reg;
        ftot     = opening ? req_reg.nfrags    : ftotal_mem[c];
        btot     = opening ? req_reg.blk_bytes : total_mem[c];
        stot     = opening ? req_reg.strm_tag  : stream_mem[c];
        pmap     = opening ? 64'd0 : map_mem[c];
        pseen    = opening ? 7'd0  : seen_mem[c];
        pbytes   = opening ? 24'd0 : bseen_mem[c];
        mismatch = (ftot != req_reg.nfrags) || (btot != req_reg.blk_bytes)
                   || (stot != req_reg.strm_tag);
        conflict = (req_reg.frag_flags[0] && req_reg.frag_num != 8'd0)
                   || (req_reg.frag_flags[1]
                       && ({1'b0, req_reg.frag_num} + 9'd1) != {2'b00, req_reg.nfrags});
        out_range = ({1'b0, req_reg.frag_num} >= {2'b00, ftot})
                    || ({1'b0, req_reg.frag_num} >= 9'(MAX_FRAGS));
        bitm     = 64'd1 << req_reg.frag_num[5:0];
        dup      = (pmap & bitm) != 64'd0;
        seen_inc = pseen + 7'd1;
        bsum     = {1'b0, pbytes} + {9'd0, req_reg.frag_bytes};
        bsat     = bsum[24] ? BYTES_MAX : bsum[23:0];
        complete = (seen_inc == ftot) && (bsat == btot);
        push_ok  = req_reg.header_ok && (hit_reg || free_ok_reg);
        frag_new = !mismatch && !out_range && !dup;
    end

    // Sweep evaluation of one context.
    logic [CTX_W-1:0] si;
    logic             expire;
    logic [63:0]      age;
    always_comb
    begin
        si     = sidx_reg[CTX_W-1:0];
        age    = req_reg.time_ns - time_mem[si];
        expire = valid_reg[si] && (tns_reg != 52'd0)
                 && (req_reg.time_ns >= time_mem[si]) && (age >= {12'd0, tns_reg});
    end

    assign stat.is_sweep   = req_reg.mode;
    assign stat.sweep_last = (sidx_reg == CNT_W'(CONTEXTS - 1));

    always_comb
    begin
        result_next = '0;
        if (cmd.push_exec)
        begin
            result_next.kind = KIND_PUSH;
            result_next.last = 1'b1;
            priority if (!req_reg.header_ok)
            begin
                result_next.status = ST_BAD_HDR;
            end
            else if (!hit_reg && !free_ok_reg)
            begin
                result_next.status = ST_NO_FREE;
            end
            else if (mismatch)
            begin
                result_next.status = ST_MISMATCH;
            end
            else if (out_range)
            begin
                result_next.status    = ST_RANGE;
                result_next.flags_bad = conflict;
            end
            else if (dup)
            begin
                result_next.status    = ST_DUPLICATE;
                result_next.flags_bad = conflict;
            end
            else if (complete)
            begin
                result_next.status     = ST_COMPLETE;
                result_next.flags_bad  = conflict;
                result_next.port_out   = req_reg.port_id;
                result_next.stream_out = req_reg.strm_tag;
                result_next.block_out  = req_reg.blk_key;
                result_next.bytes_out  = req_reg.blk_bytes;
            end
            else
            begin
                result_next.status    = ST_STORED;
                result_next.flags_bad = conflict;
            end
        end
        else if (cmd.sweep_step)
        begin
            result_next.kind          = KIND_EXPIRED;
            result_next.port_out      = port_mem[si];
            result_next.block_out     = block_mem[si];
            result_next.missing_frags = ftotal_mem[si] - seen_mem[si];
        end
        else if (cmd.sweep_done)
        begin
            result_next.kind = KIND_DONE;
            result_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.sweep_init)
        begin
            tns_reg <= 52'(timeout_val) * 52'(NS_PER_MS);
        end
        if (cmd.search)
        begin
            hit_reg      <= hit_c;
            free_ok_reg  <= free_c;
            hit_idx_reg  <= hit_i;
            free_idx_reg <= free_i;
        end
        if (cmd.push_exec && push_ok)
        begin
            if (opening)
            begin
                port_mem[c]   <= req_reg.port_id;
                block_mem[c]  <= req_reg.blk_key;
                stream_mem[c] <= req_reg.strm_tag;
                total_mem[c]  <= req_reg.blk_bytes;
                ftotal_mem[c] <= req_reg.nfrags;
            end
            // An opening context starts from the cleared values in pmap, pseen and pbytes.
            if (opening || frag_new)
            begin
                map_mem[c]   <= frag_new ? (pmap | bitm) : pmap;
                seen_mem[c]  <= frag_new ? seen_inc : pseen;
                bseen_mem[c] <= frag_new ? bsat : pbytes;
            end
            time_mem[c] <= req_reg.time_ns;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            sidx_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.push_exec || cmd.sweep_done
                                || (cmd.sweep_step && expire);
            if (cmd.push_exec && push_ok)
            begin
                if (frag_new && complete)
                begin
                    valid_reg[c] <= 1'b0;
                end
                else
                begin
                    valid_reg[c] <= 1'b1;
                end
            end
            if (cmd.sweep_init)
            begin
                sidx_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sidx_reg <= sidx_reg + CNT_W'(1);
                if (expire)
                begin
                    valid_reg[si] <= 1'b0;
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== hdl/fragment_reassembly_tracker_top.sv =====
`timescale 1ns / 1ps
// Fragment reassembly context tracker.
// Request channel: drive req and pulse start while busy is low; the request
// is taken at that edge and busy stays high until its final result is on
// the result port.
// A push (mode 0) passes through the load and push states; its one result is
// on the port as busy goes low.
// A sweep (mode 1) passes through the load, init, sweep and done states: one
// context is examined per cycle by the sweep counter, each expired one gives a
// report, and a closing result with last set follows the last context.
// Results appear on result for exactly one cycle with result_valid high;
// the receiver cannot stall, so it must take every strobe.
// Configuration: cfg_data is written to the timeout register when cfg_valid
// and cfg_ready are both high; cfg_ready is always high, and writes are
// expected only while busy is low.
// Reset clears every context and sets the timeout to 1000 ms; no clearing
// pass is needed.
module fragment_reassembly_tracker_top
    import frt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  frt_req_t    req,
    output frt_result_t result,
    output logic        result_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    frt_cmd_t    cmd;
    frt_status_t stat;
    logic [31:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    frt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    frt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (req),
        .timeout_val  (timeout_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== hdl/frt_checker.sv =====
`timescale 1ns / 1ps
module frt_checker
    import frt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input frt_result_t result,
    input logic        result_valid
);

    // A request is never accepted without busy rising next.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after request");

    // Results only while work is under way or as it ends.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a request in progress");

    // The final result of a request releases busy.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("busy still high after final result");

    // Push status results always close their request.
    a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_PUSH) |-> result.last)
        else $error("push result without last");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);
